>>> rtl/core/idh_pkg.sv
// idh_pkg: shared types and constants for the indexed deadline heap
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package idh_pkg;
  localparam int TimeW = 48;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [15:0] MinDelayReset = 16'd50;

  typedef enum logic [1:0] {
    ACT_SCHED  = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_ADV    = 2'd2,
    ACT_POP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL  = 2'd2,
    ST_KEPT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_DECIDE, S_RDLAST, S_MOVELAST,
    S_UPRD, S_UPCMP, S_DNRD, S_DNRD2, S_DNCMP, S_PLACE, S_OUT
  } state_t;
endpackage
`default_nettype wire

>>> rtl/core/indexed_deadline_heap_top.sv
// indexed_deadline_heap_top: min-heap scheduler with per-cell slot map
// depends on idh_pkg
// sift up steps through S_UPRD and S_UPCMP per level, sift down through S_DNRD, S_DNRD2 and
// S_DNCMP per level, over one heap port; the longest wait from input beat to result is set by a removal walking down
// one item at a time; the next beat is taken the cycle after the result beat
// after reset a clearing pass sweeps every slot map entry, no item taken
// reset clears time and count and sets min_delay to 50
`timescale 1ns / 1ps
`default_nettype none
module indexed_deadline_heap_top #(
  parameter int HEAP_CAPACITY = 1024,
  parameter int CELLS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [11:0] in_cell_req,
  input  wire logic [15:0] in_delay,
  input  wire logic [15:0] in_time_step,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [11:0]      out_popped_cell,
  output logic [47:0]      out_popped_due,
  output logic [10:0]      out_pending,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_min_delay
);
  import idh_pkg::*;

  localparam int AW = $clog2(HEAP_CAPACITY) + 1; // positions and count
  localparam int SW = $clog2(CELLS);
  localparam int MW = AW;                        // slot map holds pos+1
  localparam int HI = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
  localparam logic [AW-1:0] Cap = AW'(HEAP_CAPACITY);

  // memories
  logic [TimeW-1:0] hdue_mem [HEAP_CAPACITY];
  logic [11:0]      hcell_mem [HEAP_CAPACITY];
  logic [MW-1:0]    smap_mem [CELLS];

  state_t state_r, state_nxt;
  logic [15:0] min_delay_r;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt, chd_r, chd_nxt;
  logic [TimeW-1:0] due_r, due_nxt, cdue_r, cdue_nxt;
  logic [11:0] cell_r, cell_nxt, ccell_r, ccell_nxt;
  logic [1:0] act_r;
  logic [11:0] req_r;
  logic [15:0] dly_r, stp_r;
  logic [SW-1:0] clr_r;
  logic [1:0] st_r, st_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [TimeW-1:0] pd_r, pd_nxt;
  logic ovalid_r;

  // up-sift moves during a removal must not descend afterwards
  logic up_moved_r, up_moved_nxt;

  // heap read port (registered)
  logic [HI-1:0] hra;
  logic [TimeW-1:0] hrd_due;
  logic [11:0] hrd_cell;
  // heap write port
  logic hwe;
  logic [HI-1:0] hwa;
  logic [TimeW-1:0] hwd_due;
  logic [11:0] hwd_cell;
  // slot map ports
  logic [SW-1:0] sra;
  logic [MW-1:0] srd;
  logic swe;
  logic [SW-1:0] swa;
  logic [MW-1:0] swd;

  always_ff @(posedge clk) begin
    if (hwe) begin
      hdue_mem[hwa]  <= hwd_due;
      hcell_mem[hwa] <= hwd_cell;
    end
    hrd_due  <= hdue_mem[hra];
    hrd_cell <= hcell_mem[hra];
  end

  always_ff @(posedge clk) begin
    if (swe) smap_mem[swa] <= swd;
    srd <= smap_mem[sra];
  end

  // add with saturation for schedule and advance
  logic [15:0] add_sel;
  logic [TimeW:0] due_sum, adv_sum;
  assign add_sel = (dly_r > min_delay_r) ? dly_r : min_delay_r;
  assign due_sum = {1'b0, now_r} + {{(TimeW-16+1){1'b0}}, add_sel};
  assign adv_sum = {1'b0, now_r} + {{(TimeW-16+1){1'b0}}, stp_r};

  logic req_ok, slot_hit;
  assign req_ok = ({20'd0, req_r} < 32'(CELLS));
  assign slot_hit = (srd != '0) && ((srd - MW'(1)) < cnt_r);

  always_comb begin
    state_nxt = state_r;
    now_nxt = now_r; cnt_nxt = cnt_r; pos_nxt = pos_r; chd_nxt = chd_r;
    due_nxt = due_r; cdue_nxt = cdue_r; cell_nxt = cell_r; ccell_nxt = ccell_r;
    st_nxt = st_r; pc_nxt = pc_r; pd_nxt = pd_r;
    up_moved_nxt = up_moved_r;
    hra = '0; hwe = 1'b0; hwa = '0; hwd_due = due_r; hwd_cell = cell_r;
    sra = req_r[SW-1:0]; swe = 1'b0; swa = '0; swd = '0;
    case (state_r)
      S_CLEAR: begin
        swe = 1'b1; swa = clr_r;
        if (clr_r == SW'(CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        sra = in_cell_req[SW-1:0];
        hra = '0;
        up_moved_nxt = 1'b0;
        if (in_valid && in_ready) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        // slot map and root read are registered now
        st_nxt = ST_DONE; pc_nxt = '0; pd_nxt = '0;
        hra = HI'(srd - MW'(1));
        state_nxt = S_DECIDE;
        case (action_t'(act_r))
          ACT_ADV: begin
            now_nxt = adv_sum[TimeW] ? TimeMax : adv_sum[TimeW-1:0];
            state_nxt = S_OUT;
          end
          ACT_POP: begin
            if (cnt_r != '0 && hrd_due <= now_r) begin
              pc_nxt = hrd_cell; pd_nxt = hrd_due;
              pos_nxt = '0;
              swe = 1'b1; swa = hrd_cell[SW-1:0];
              cnt_nxt = cnt_r - AW'(1);
              state_nxt = (cnt_r == AW'(1)) ? S_OUT : S_RDLAST;
            end else begin
              st_nxt = ST_ABSENT; state_nxt = S_OUT;
            end
          end
          ACT_CANCEL: begin
            if (!req_ok || !slot_hit) begin
              st_nxt = ST_ABSENT; state_nxt = S_OUT;
            end else begin
              pos_nxt = srd - MW'(1);
              swe = 1'b1; swa = req_r[SW-1:0];
              cnt_nxt = cnt_r - AW'(1);
              state_nxt = ((srd - MW'(1)) >= (cnt_r - AW'(1))) ? S_OUT : S_RDLAST;
            end
          end
          default: begin
            due_nxt = due_sum[TimeW] ? TimeMax : due_sum[TimeW-1:0];
            cell_nxt = req_r;
            if (!req_ok) begin
              st_nxt = ST_ABSENT; state_nxt = S_OUT;
            end else if (slot_hit) begin
              pos_nxt = srd - MW'(1);
              state_nxt = S_DECIDE;
            end else if (cnt_r >= Cap) begin
              st_nxt = ST_FULL; state_nxt = S_OUT;
            end else begin
              pos_nxt = cnt_r;
              cnt_nxt = cnt_r + AW'(1);
              state_nxt = S_UPRD;
            end
          end
        endcase
      end
      S_DECIDE: begin
        // existing entry of a queued cell is in hrd
        if (due_r < hrd_due) state_nxt = S_UPRD;
        else begin st_nxt = ST_KEPT; state_nxt = S_OUT; end
      end
      S_RDLAST: begin
        hra = cnt_r[HI-1:0];
        state_nxt = S_MOVELAST;
      end
      S_MOVELAST: begin
        // moved entry goes to pos; decide direction via parent read
        due_nxt = hrd_due; cell_nxt = hrd_cell;
        if (pos_r == '0) state_nxt = S_DNRD;
        else begin
          hra = HI'((pos_r - AW'(1)) >> 1);
          state_nxt = S_UPCMP;
        end
      end
      S_UPRD: begin
        if (pos_r == '0) state_nxt = S_PLACE;
        else begin
          hra = HI'((pos_r - AW'(1)) >> 1);
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (hrd_due <= due_r) begin
          state_nxt = (act_r == ACT_SCHED || up_moved_r) ? S_PLACE : S_DNRD;
        end else begin
          hwe = 1'b1; hwa = pos_r[HI-1:0];
          hwd_due = hrd_due; hwd_cell = hrd_cell;
          swe = 1'b1; swa = hrd_cell[SW-1:0]; swd = pos_r + MW'(1);
          pos_nxt = (pos_r - AW'(1)) >> 1;
          up_moved_nxt = 1'b1;
          state_nxt = S_UPRD;
        end
      end
      S_DNRD: begin
        if ((pos_r << 1) + AW'(1) >= cnt_r) state_nxt = S_PLACE;
        else begin
          hra = HI'((pos_r << 1) + AW'(1));
          state_nxt = S_DNRD2;
        end
      end
      S_DNRD2: begin
        cdue_nxt = hrd_due; ccell_nxt = hrd_cell;
        chd_nxt = (pos_r << 1) + AW'(1);
        hra = HI'((pos_r << 1) + AW'(2));
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        logic [AW-1:0] c;
        logic [TimeW-1:0] cd;
        logic [11:0] cc;
        c = chd_r; cd = cdue_r; cc = ccell_r;
        if (chd_r + AW'(1) < cnt_r && hrd_due < cdue_r) begin
          c = chd_r + AW'(1); cd = hrd_due; cc = hrd_cell;
        end
        if (cd >= due_r) state_nxt = S_PLACE;
        else begin
          hwe = 1'b1; hwa = pos_r[HI-1:0];
          hwd_due = cd; hwd_cell = cc;
          swe = 1'b1; swa = cc[SW-1:0]; swd = pos_r + MW'(1);
          pos_nxt = c;
          state_nxt = S_DNRD;
        end
      end
      S_PLACE: begin
        hwe = 1'b1; hwa = pos_r[HI-1:0];
        swe = 1'b1; swa = cell_r[SW-1:0]; swd = pos_r + MW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // no new beat while a result waits
  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_status = st_r;
  assign out_popped_cell = pc_r;
  assign out_popped_due = pd_r;
  assign out_pending = 11'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      now_r <= '0;
      cnt_r <= '0;
      min_delay_r <= MinDelayReset;
      ovalid_r <= 1'b0;
      up_moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      up_moved_r <= up_moved_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + SW'(1);
      now_r <= now_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_valid) min_delay_r <= cfg_min_delay;
      if (state_r == S_OUT && !ovalid_r) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; chd_r <= chd_nxt;
    due_r <= due_nxt; cdue_r <= cdue_nxt;
    cell_r <= cell_nxt; ccell_r <= ccell_nxt;
    st_r <= st_nxt; pc_r <= pc_nxt; pd_r <= pd_nxt;
    if (in_valid && in_ready) begin
      act_r <= in_action; req_r <= in_cell_req;
      dly_r <= in_delay; stp_r <= in_time_step;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/idh_checker.sv
// idh_checker: port-level checks for the heap scheduler
// depends on idh_pkg; bound to indexed_deadline_heap_top
`timescale 1ns / 1ps
`default_nettype none
module idh_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_status,
  input wire logic [11:0] out_popped_cell,
  input wire logic [10:0] out_pending
);
  import idh_pkg::*;
  // one item in flight: no new beat while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // valid and pending count hold until the result is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pending))
    else $error("result dropped");
  // a failed item of any action reports no cell
  a_nocell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_popped_cell == '0)
    else $error("cell on failed item");
  // bounded count
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending <= 11'd1024) else $error("count overflow");
endmodule
bind indexed_deadline_heap_top idh_checker u_idh_checker (.*);
`default_nettype wire

>>> bench/indexed_deadline_heap_top_tb.sv
// indexed_deadline_heap_top_tb: self-checking bench for the indexed deadline heap
// depends on idh_pkg and indexed_deadline_heap_top; a built-in heap predictor checks each result
`timescale 1ns / 1ps
module indexed_deadline_heap_top_tb;
  import idh_pkg::*;

  localparam int Depth = 1024;
  localparam int NumCells = 4096;

  typedef struct {
    action_t     act;
    logic [11:0] cell_id;
    logic [15:0] delay;
    logic [15:0] step;
  } req_t;

  typedef struct {
    status_t     status;
    logic [11:0] cell_id;
    logic [47:0] due;
    logic [10:0] pending;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [11:0] in_cell_req = '0;
  logic [15:0] in_delay = '0;
  logic [15:0] in_time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [11:0] out_popped_cell;
  logic [47:0] out_popped_due;
  logic [10:0] out_pending;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_min_delay = '0;

  req_t req_q[$];
  res_t due_results_q[$];
  req_t cur_req;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 1'b0;

  // predictor state
  logic [47:0] q_due[Depth];
  logic [11:0] q_cell[Depth];
  int unsigned cell_slot[NumCells];
  int unsigned q_count = 0;
  logic [47:0] now_ms = '0;
  logic [15:0] min_delay_m;

  indexed_deadline_heap_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_cell_req(in_cell_req), .in_delay(in_delay), .in_time_step(in_time_step),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_popped_cell(out_popped_cell), .out_popped_due(out_popped_due),
    .out_pending(out_pending),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_delay(cfg_min_delay)
  );

  always #6 clk = ~clk;

  // heap maintenance of the predictor
  function automatic void heap_place(int unsigned pos, logic [47:0] d, logic [11:0] c);
    q_due[pos] = d;
    q_cell[pos] = c;
    cell_slot[c] = pos + 1;
  endfunction

  function automatic void heap_raise(int unsigned pos);
    logic [47:0] d;
    logic [11:0] c;
    int unsigned parent;
    d = q_due[pos];
    c = q_cell[pos];
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (q_due[parent] <= d) break;
      heap_place(pos, q_due[parent], q_cell[parent]);
      pos = parent;
    end
    heap_place(pos, d, c);
  endfunction

  function automatic void heap_remove(int unsigned pos);
    logic [47:0] d;
    logic [11:0] c;
    int unsigned child;
    cell_slot[q_cell[pos]] = 0;
    q_count--;
    if (pos >= q_count) return;
    d = q_due[q_count];
    c = q_cell[q_count];
    heap_place(pos, d, c);
    if (pos > 0 && d < q_due[(pos - 1) / 2]) begin
      heap_raise(pos);
      return;
    end
    while (2 * pos + 1 < q_count) begin
      child = 2 * pos + 1;
      if (child + 1 < q_count && q_due[child + 1] < q_due[child]) child++;
      if (q_due[child] >= d) break;
      heap_place(pos, q_due[child], q_cell[child]);
      pos = child;
    end
    heap_place(pos, d, c);
  endfunction

  // expected result of one accepted beat
  function automatic res_t scheduler_outcome(req_t r);
    res_t o;
    logic [48:0] sum;
    logic [47:0] d;
    int unsigned slot;
    o.status = ST_DONE;
    o.cell_id = '0;
    o.due = '0;
    case (r.act)
      ACT_SCHED: begin
        sum = {1'b0, now_ms} + ((r.delay > min_delay_m) ? r.delay : min_delay_m);
        d = sum[48] ? TimeMax : sum[47:0];
        slot = cell_slot[r.cell_id];
        if (slot != 0 && slot - 1 < q_count) begin
          if (d < q_due[slot - 1]) begin
            q_due[slot - 1] = d;
            heap_raise(slot - 1);
          end else begin
            o.status = ST_KEPT;
          end
        end else if (q_count >= Depth) begin
          o.status = ST_FULL;
        end else begin
          heap_place(q_count, d, r.cell_id);
          q_count++;
          heap_raise(q_count - 1);
        end
      end
      ACT_CANCEL: begin
        slot = cell_slot[r.cell_id];
        if (slot == 0 || slot - 1 >= q_count) o.status = ST_ABSENT;
        else heap_remove(slot - 1);
      end
      ACT_ADV: begin
        sum = {1'b0, now_ms} + r.step;
        now_ms = sum[48] ? TimeMax : sum[47:0];
      end
      default: begin
        if (q_count > 0 && q_due[0] <= now_ms) begin
          o.cell_id = q_cell[0];
          o.due = q_due[0];
          heap_remove(0);
        end else begin
          o.status = ST_ABSENT;
        end
      end
    endcase
    o.pending = q_count[10:0];
    return o;
  endfunction

  // driver: one beat at a time from the request queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_results_q.push_back(scheduler_outcome(cur_req));
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          in_action <= cur_req.act;
          in_cell_req <= cur_req.cell_id;
          in_delay <= cur_req.delay;
          in_time_step <= cur_req.step;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats against the oldest expectation, plus config tracking
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      min_delay_m = MinDelayReset;
    end else begin
      if (cfg_valid && cfg_ready) min_delay_m = cfg_min_delay;
      if (out_valid && out_ready) begin
        if (due_results_q.size() == 0) begin
          $display("%0t: unexpected result st=%0d cell=%0d due=%0d pend=%0d", $time,
                   out_status, out_popped_cell, out_popped_due, out_pending);
          failed = 1'b1;
        end else begin
          e = due_results_q.pop_front();
          if (out_status !== e.status || out_popped_cell !== e.cell_id ||
              out_popped_due !== e.due || out_pending !== e.pending) begin
            $display("%0t: expected st=%0d cell=%0d due=%0d pend=%0d", $time,
                     e.status, e.cell_id, e.due, e.pending);
            $display("%0t: actual   st=%0d cell=%0d due=%0d pend=%0d", $time,
                     out_status, out_popped_cell, out_popped_due, out_pending);
            failed = 1'b1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(action_t a, int c, int d, int s);
    req_t r;
    r.act = a;
    r.cell_id = 12'(c);
    r.delay = 16'(d);
    r.step = 16'(s);
    req_q.push_back(r);
  endtask

  // random mix, mostly a small cell pool so cancels and reschedules hit
  task automatic add_random(int n);
    int c, d, s, w;
    repeat (n) begin
      c = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(31);
      d = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(300);
      s = ($urandom_range(4) == 0) ? $urandom_range(65535) :
          ($urandom_range(9) == 0) ? 0 : $urandom_range(120);
      w = $urandom_range(99);
      if (w < 40) add_req(ACT_SCHED, c, d, $urandom_range(65535));
      else if (w < 55) add_req(ACT_CANCEL, c, $urandom_range(65535), $urandom_range(65535));
      else if (w < 75) add_req(ACT_ADV, $urandom_range(4095), $urandom_range(65535), s);
      else add_req(ACT_POP, $urandom_range(4095), $urandom_range(65535), $urandom_range(65535));
    end
  endtask

  // wait until every request has been answered and the block has settled
  task automatic drain();
    while (req_q.size() > 0 || in_valid || due_results_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_min_delay(int v);
    cfg_min_delay <= 16'(v);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(int snd, int rcv);
    @(negedge clk);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: keep, pull earlier, absent, empty pop, equal due times
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_SCHED, 0, 0, 0);
    add_req(ACT_SCHED, 0, 10, 0);
    add_req(ACT_SCHED, 4095, 65535, 0);
    add_req(ACT_SCHED, 5, 100, 0);
    add_req(ACT_SCHED, 5, 60, 0);
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_CANCEL, 7, 0, 0);
    add_req(ACT_ADV, 0, 0, 0);
    add_req(ACT_ADV, 0, 0, 65535);
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_CANCEL, 4095, 0, 0);
    add_req(ACT_CANCEL, 4095, 0, 0);
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_SCHED, 1, 0, 0);
    add_req(ACT_SCHED, 2, 0, 0);
    add_req(ACT_SCHED, 3, 0, 0);
    add_req(ACT_SCHED, 4, 0, 0);
    add_req(ACT_ADV, 0, 0, 50);
    add_req(ACT_CANCEL, 2, 0, 0);
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_POP, 0, 0, 0);
    add_req(ACT_POP, 0, 0, 0);
    drain();
    write_min_delay(0);
    add_random(35);
    drain();
    write_min_delay(65535);
    set_idling(80, 0);
    add_random(35);
    drain();
    write_min_delay($urandom_range(1, 400));
    set_idling(0, 80);
    add_random(35);
    drain();
    write_min_delay(0);
    set_idling(27, 27);
    add_random(35);
    drain();
    // fill the heap past capacity, then some traffic at the full edge
    write_min_delay($urandom_range(0, 65535));
    set_idling(0, 0);
    for (int i = 0; i < 1030; i++) add_req(ACT_SCHED, 2000 + i, $urandom_range(65535), 0);
    add_req(ACT_CANCEL, 2000, 0, 0);
    add_req(ACT_SCHED, 3900, 0, 0);
    add_req(ACT_SCHED, 3901, 0, 0);
    add_req(ACT_ADV, 0, 0, 65535);
    add_req(ACT_ADV, 0, 0, 65535);
    add_random(20);
    drain();
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end
endmodule

>>> indexed_deadline_heap_top.f
rtl/core/idh_pkg.sv
rtl/core/indexed_deadline_heap_top.sv
rtl/core/idh_checker.sv
bench/indexed_deadline_heap_top_tb.sv
